// File: hw/rtl/mqs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_pkg
// Shared constants and elaboration-time table builders for the mapping
// quality unit.
// ----------------------------------------------------------------------------
package mqs_pkg;

    localparam int unsigned LN2_Q12      = 2839;
    localparam int unsigned HIT_GAIN_Q12 = 17789;
    localparam int unsigned HIT_BIAS_Q24 = 8371831;
    localparam int unsigned MAPQ_CAP     = 60;
    localparam int unsigned ONE_Q16      = 65536;

    // Unsigned shift-subtract division, used only when building tables.
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int k = 63; k >= 0; k--) begin
            rem = (rem << 1) | ((num >> k) & 64'd1);
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // ln(1 + i/2^tb) in Q0.12, via 2*atanh(t), t = i/(2*2^tb + i), 31 terms.
    function automatic logic [11:0] ln_frac(input int unsigned i,
                                            input int unsigned tb);
        longint unsigned den;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned res;
        den  = (64'd2 << tb) + longint'(i);
        t    = udiv64(longint'(i) << 32, den);
        t2   = (t * t) >> 32;
        term = t;
        sum  = 0;
        for (int unsigned k = 0; k < 31; k++) begin
            sum  = sum + udiv64(term, longint'(2 * k + 1));
            term = (term * t2) >> 32;
        end
        res = (2 * sum + (64'd1 << 19)) >> 20;
        return res[11:0];
    endfunction

    // Score penalty for small best scores, Q1.16.
    function automatic logic [16:0] score_pen(input int unsigned b);
        longint unsigned v;
        v = (longint'(b) * 65536 + 50) / 100;
        return v[16:0];
    endfunction

    // Seed-count penalty for small chains, Q1.16.
    function automatic logic [16:0] seed_pen(input int unsigned c);
        longint unsigned v;
        v = (longint'(c) * 65536 + 5) / 10;
        return v[16:0];
    endfunction

endpackage

// File: hw/rtl/mqs_ln.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_ln
// Natural log of a 17-bit integer in Q4.12: leading-one position times ln 2
// plus a fraction table lookup. One register stage.
// ----------------------------------------------------------------------------
module mqs_ln #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [16:0] i_val,
    output logic [15:0] o_ln
);
    localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;

    logic [11:0] tab [TAB_SIZE];

    // fraction table, constant
    for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
        localparam logic [11:0] FRAC = mqs_pkg::ln_frac(g, LOG_TABLE_BITS);
        assign tab[g] = FRAC;
    end

    logic [4:0]                     exp_pos;
    logic [16+LOG_TABLE_BITS:0]     aligned;
    logic [LOG_TABLE_BITS-1:0]      idx;
    logic [15:0]                    n_ln;
    logic [15:0]                    r_ln;

    // leading one search
    always_comb begin
        exp_pos = '0;
        for (int k = 0; k < 17; k++) begin
            if (i_val[k]) exp_pos = 5'(k);
        end
    end

    // bits below the leading one, padded or truncated
    assign aligned = {i_val, {LOG_TABLE_BITS{1'b0}}} >> exp_pos;
    assign idx     = aligned[LOG_TABLE_BITS-1:0];
    assign n_ln    = 16'(16'(exp_pos) * 16'(mqs_pkg::LN2_Q12)) + 16'(tab[idx]);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ln <= n_ln;
        end
    end

    assign o_ln = r_ln;
endmodule

// File: hw/rtl/mqs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_div
// Pipelined restoring divider: 31-bit dividend by 15-bit divisor, quotient
// of 17 bits, one quotient bit per stage. The dividend's top part must be
// below the divisor. Side data and a valid bit travel along.
// ----------------------------------------------------------------------------
module mqs_div #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  logic [30:0]       i_num,
    input  logic [14:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [16:0]       o_quo,
    output logic [SIDE_W-1:0] o_side
);
    localparam int STAGES = 17;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [14:0]       in_rem;
        logic [16:0]       in_low;
        logic [16:0]       in_quo;
        logic [14:0]       in_den;
        logic [SIDE_W-1:0] in_side;
        logic              in_vld;
        logic [15:0]       trial;
        logic              take;
        logic [14:0]       n_rem;
        logic [16:0]       n_quo;
        logic [14:0]       r_rem;
        logic [16:0]       r_low;
        logic [16:0]       r_quo;
        logic [14:0]       r_den;
        logic [SIDE_W-1:0] r_side;
        logic              r_vld;

        if (k == 0) begin : g_first
            assign in_rem  = {1'b0, i_num[30:17]};
            assign in_low  = i_num[16:0];
            assign in_quo  = '0;
            assign in_den  = i_den;
            assign in_side = i_side;
            assign in_vld  = i_valid;
        end else begin : g_next
            assign in_rem  = g_stage[k-1].r_rem;
            assign in_low  = g_stage[k-1].r_low;
            assign in_quo  = g_stage[k-1].r_quo;
            assign in_den  = g_stage[k-1].r_den;
            assign in_side = g_stage[k-1].r_side;
            assign in_vld  = g_stage[k-1].r_vld;
        end

        // one restoring step on quotient bit 16-k
        always_comb begin
            trial = {in_rem, in_low[16-k]};
            take  = (trial >= {1'b0, in_den});
            n_rem = take ? 15'(trial - {1'b0, in_den}) : trial[14:0];
            n_quo = in_quo;
            n_quo[16-k] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ce) begin
                r_vld <= in_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem  <= n_rem;
                r_low  <= in_low;
                r_quo  <= n_quo;
                r_den  <= in_den;
                r_side <= in_side;
            end
        end
    end

    assign o_valid = g_stage[STAGES-1].r_vld;
    assign o_quo   = g_stage[STAGES-1].r_quo;
    assign o_side  = g_stage[STAGES-1].r_side;
endmodule

// File: hw/rtl/mapping_quality_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapping_quality_score_unit
// Mapping quality (0..60) of a read's primary alignment.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream s_axis_* carries one read per request: best and second
//    chain score, seed count, identity (Q1.16) and other-hit count.
//  - Master stream m_axis_* returns one quality per read, in order.
//  - From input request to output valid a read passes one input
//    stage, one stage for penalty product and both log lookups, 17 stages
//    of the ratio divider (one quotient bit each), then four stages for
//    square, products, rounding and hit penalty; the divider sets the depth.
//  - Throughput is one read per cycle while the receiver does not stall.
//  - All stages share one enable: the pipe advances when the output
//    register is empty or being taken. While the receiver stalls with a
//    result waiting, the whole pipe holds and s_axis_tready is low; nothing
//    is lost or repeated.
//  - Synchronous active-low reset clears all valid bits; the pipe is empty
//    and ready as soon as reset is released.
// ----------------------------------------------------------------------------
module mapping_quality_score_unit #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] best_score, [31:16] second_score, [47:32] best_seed_count,
    // [64:48] identity, [80:65] other_hit_count, [87:81] zero
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] quality, [7:6] zero
    output logic [7:0]  m_axis_tdata
);
    localparam int SIDE_W = 1 + 17 + 16 + 16;

    logic ce;

    // constant penalty tables
    logic [16:0] score_tab [128];
    logic [16:0] seed_tab  [16];
    for (genvar g = 0; g < 128; g++) begin : g_stab
        localparam logic [16:0] PV = mqs_pkg::score_pen(g);
        assign score_tab[g] = PV;
    end
    for (genvar g = 0; g < 16; g++) begin : g_ctab
        localparam logic [16:0] CV = mqs_pkg::seed_pen(g);
        assign seed_tab[g] = CV;
    end

    // ---------------- stage 0: clamps and penalty ----------------
    logic signed [15:0] in_best;
    logic signed [15:0] in_second;
    logic [15:0]        in_seeds;
    logic [16:0]        in_ident;
    logic [15:0]        in_hits;
    logic               n0_pos;
    logic [14:0]        n0_s;
    logic [16:0]        n0_ident;
    logic [16:0]        ps;
    logic [16:0]        pc;

    assign in_best   = s_axis_tdata[15:0];
    assign in_second = s_axis_tdata[31:16];
    assign in_seeds  = s_axis_tdata[47:32];
    assign in_ident  = s_axis_tdata[64:48];
    assign in_hits   = s_axis_tdata[80:65];

    always_comb begin
        n0_pos = (in_best > 16'sd0);
        if (in_second < 16'sd0) begin
            n0_s = '0;
        end else if (in_second > in_best) begin
            n0_s = in_best[14:0];
        end else begin
            n0_s = in_second[14:0];
        end
        n0_ident = (in_ident > 17'(mqs_pkg::ONE_Q16)) ? 17'(mqs_pkg::ONE_Q16) : in_ident;
        ps = (in_best > 16'sd100) ? 17'(mqs_pkg::ONE_Q16) : score_tab[in_best[6:0]];
        pc = (in_seeds > 16'd10) ? 17'(mqs_pkg::ONE_Q16) : seed_tab[in_seeds[3:0]];
    end

    logic        r0_vld;
    logic        r0_pos;
    logic [14:0] r0_b;
    logic [14:0] r0_s;
    logic [16:0] r0_ident;
    logic [16:0] r0_p;
    logic [16:0] r0_h1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (ce) begin
            r0_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_pos   <= n0_pos;
            r0_b     <= in_best[14:0];
            r0_s     <= n0_s;
            r0_ident <= n0_ident;
            r0_p     <= (ps < pc) ? ps : pc;
            r0_h1    <= 17'(in_hits) + 17'd1;
        end
    end

    // ---------------- stage 1: penalty product and logs ----------------
    logic [33:0] ident_prod;
    logic [15:0] ln_best;
    logic [15:0] ln_hits;

    assign ident_prod = 34'(r0_ident) * 34'(r0_p);

    mqs_ln #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_ln_best (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_val ({2'b00, r0_b}),
        .o_ln  (ln_best)
    );

    mqs_ln #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_ln_hits (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_val (r0_h1),
        .o_ln  (ln_hits)
    );

    logic        r1_vld;
    logic        r1_pos;
    logic [14:0] r1_b;
    logic [14:0] r1_s;
    logic [16:0] r1_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (ce) begin
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r1_pos <= r0_pos;
            r1_b   <= r0_b;
            r1_s   <= r0_s;
            r1_a   <= ident_prod[32:16];
        end
    end

    // ---------------- ratio divider: second/best in Q1.16 ----------------
    logic [30:0]       div_num;
    logic              div_vld;
    logic [16:0]       div_quo;
    logic [SIDE_W-1:0] div_side;

    assign div_num = {r1_s, 16'd0} + 31'(r1_b >> 1);

    mqs_div #(.SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r1_vld),
        .i_num   (div_num),
        .i_den   (r1_b),
        .i_side  ({r1_pos, r1_a, ln_best, ln_hits}),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ---------------- stage A: 1 - ratio^2 ----------------
    logic [33:0] sq;
    logic [17:0] x2;

    assign sq = 34'(div_quo) * 34'(div_quo) + 34'd32768;
    assign x2 = sq[33:16];

    logic        ra_vld;
    logic        ra_pos;
    logic [16:0] ra_a;
    logic [15:0] ra_lnb;
    logic [15:0] ra_lnh;
    logic [16:0] ra_om;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
        end else if (ce) begin
            ra_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            {ra_pos, ra_a, ra_lnb, ra_lnh} <= div_side;
            ra_om <= 17'(18'(mqs_pkg::ONE_Q16) - x2);
        end
    end

    // ---------------- stage B: scale and hit penalty product ----------------
    logic [33:0] am_prod;

    assign am_prod = 34'(ra_a) * 34'(ra_om);

    logic        rb_vld;
    logic        rb_pos;
    logic [16:0] rb_m;
    logic [15:0] rb_lnb;
    logic [31:0] rb_hp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_vld <= 1'b0;
        end else if (ce) begin
            rb_vld <= ra_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            rb_pos <= ra_pos;
            rb_m   <= am_prod[32:16];
            rb_lnb <= ra_lnb;
            rb_hp  <= 32'(ra_lnh) * 32'(mqs_pkg::HIT_GAIN_Q12)
                      + 32'(mqs_pkg::HIT_BIAS_Q24);
        end
    end

    // ---------------- stage C: times ln(best) ----------------
    logic        rc_vld;
    logic        rc_pos;
    logic [32:0] rc_prod;
    logic [7:0]  rc_hitpen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rc_vld <= 1'b0;
        end else if (ce) begin
            rc_vld <= rb_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            rc_pos    <= rb_pos;
            rc_prod   <= 33'(rb_m) * 33'(rb_lnb);
            rc_hitpen <= rb_hp[31:24];
        end
    end

    // ---------------- stage D: round, cap, subtract ----------------
    logic [39:0] scaled;
    logic [11:0] raw_full;
    logic [7:0]  raw;
    logic [5:0]  n_quality;

    always_comb begin
        scaled   = {2'b00, rc_prod, 5'd0} + {4'd0, rc_prod, 3'd0} + (40'd1 << 27);
        raw_full = scaled[39:28];
        if (!rc_pos) begin
            raw = '0;
        end else if (raw_full > 12'(mqs_pkg::MAPQ_CAP)) begin
            raw = 8'(mqs_pkg::MAPQ_CAP);
        end else begin
            raw = raw_full[7:0];
        end
        n_quality = (raw > rc_hitpen) ? 6'(raw - rc_hitpen) : 6'd0;
    end

    logic       rd_vld;
    logic [5:0] rd_quality;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld <= 1'b0;
        end else if (ce) begin
            rd_vld <= rc_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            rd_quality <= n_quality;
        end
    end

    // pipe advances when output is free or being taken; no requests in reset
    assign ce            = !rd_vld || m_axis_tready;
    assign s_axis_tready = ce && i_rst_n;
    assign m_axis_tvalid = rd_vld;
    assign m_axis_tdata  = {2'b00, rd_quality};
endmodule

// File: hw/rtl/mqs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqs_checker
// Port-level checks for the mapping quality unit, bound to the top level.
// ----------------------------------------------------------------------------
module mqs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    // quality stays in range with zero padding
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:0] <= 6'd60) && (m_axis_tdata[7:6] == 2'b00))
        else $error("quality out of range");

    // reset empties the pipe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
endmodule

bind mapping_quality_score_unit mqs_checker u_mqs_checker (.*);
